// ----- design/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int THR_W     = 31;
  localparam int NLANE     = 9;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ADJ_W     = PROD_W + 1;
  localparam int SPLIT     = ELEM_W;
  localparam int HI_W      = ADJ_W - SPLIT;
  localparam int PP_W      = ELEM_W + HI_W;
  localparam int DET_W     = ELEM_W + ADJ_W + 1;
  localparam int DIV_W     = DET_W;
  localparam int QUO_W     = ELEM_W + 1;
  localparam int NSTG      = QUO_W;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [DIV_W-1:0]         wide_t;
  typedef logic [QUO_W-1:0]         quo_t;

  typedef struct packed {
    elem_t m_r0c0;
    elem_t m_r0c1;
    elem_t m_r0c2;
    elem_t m_r1c0;
    elem_t m_r1c1;
    elem_t m_r1c2;
    elem_t m_r2c0;
    elem_t m_r2c1;
    elem_t m_r2c2;
  } in_data_t;

  typedef struct packed {
    elem_t inv_r0c0;
    elem_t inv_r0c1;
    elem_t inv_r0c2;
    elem_t inv_r1c0;
    elem_t inv_r1c1;
    elem_t inv_r1c2;
    elem_t inv_r2c0;
    elem_t inv_r2c1;
    elem_t inv_r2c2;
    elem_t det_value;
    logic  singular;
    logic  saturated;
  } out_data_t;

  // Per-item status that rides alongside the divider lanes.
  typedef struct packed {
    logic  singular;
    logic  det_clip;
    elem_t det_value;
  } side_t;

endpackage

// ----- design/mi3_adj.sv -----
// ----------------------------------------------------------------------------
// mi3_adj
// Two stages: the eighteen 2x2 products, then the signed adjugate elements.
// ----------------------------------------------------------------------------
module mi3_adj (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  mi3_pkg::in_data_t             in_data,
  output logic                          adj_valid,
  output mi3_pkg::adj_t                 adj [mi3_pkg::NLANE],
  output mi3_pkg::elem_t                mtop [3]
);
  import mi3_pkg::*;

  localparam int MA [NLANE] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int MB [NLANE] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
  localparam int MC [NLANE] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
  localparam int MD [NLANE] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};

  elem_t m [NLANE];
  prod_t pa_r [NLANE];
  prod_t pb_r [NLANE];
  elem_t mt_r [3];
  adj_t  adj_r [NLANE];
  elem_t mt2_r [3];
  logic  v1_r, v2_r;

  assign m[0] = in_data.m_r0c0;
  assign m[1] = in_data.m_r0c1;
  assign m[2] = in_data.m_r0c2;
  assign m[3] = in_data.m_r1c0;
  assign m[4] = in_data.m_r1c1;
  assign m[5] = in_data.m_r1c2;
  assign m[6] = in_data.m_r2c0;
  assign m[7] = in_data.m_r2c1;
  assign m[8] = in_data.m_r2c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    always_ff @(posedge clk) begin
      pa_r[i] <= PROD_W'(m[MA[i]]) * PROD_W'(m[MD[i]]);
      pb_r[i] <= PROD_W'(m[MB[i]]) * PROD_W'(m[MC[i]]);
      // Odd positions of the adjugate carry a negative cofactor sign.
      if (i % 2 == 1) begin
        adj_r[i] <= ADJ_W'(pb_r[i]) - ADJ_W'(pa_r[i]);
      end else begin
        adj_r[i] <= ADJ_W'(pa_r[i]) - ADJ_W'(pb_r[i]);
      end
    end
    assign adj[i] = adj_r[i];
  end

  for (genvar j = 0; j < 3; j++) begin : g_top
    always_ff @(posedge clk) begin
      mt_r[j]  <= m[j];
      mt2_r[j] <= mt_r[j];
    end
    assign mtop[j] = mt2_r[j];
  end

  assign adj_valid = v2_r;

endmodule

// ----- design/mi3_det.sv -----
// ----------------------------------------------------------------------------
// mi3_det
// Determinant by expansion along row 0, each wide product split in halves.
// ----------------------------------------------------------------------------
module mi3_det (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adj_valid,
  input  mi3_pkg::adj_t                 adj [mi3_pkg::NLANE],
  input  mi3_pkg::elem_t                mtop [3],
  output logic                          det_valid,
  output mi3_pkg::det_t                 det,
  output mi3_pkg::adj_t                 adj_out [mi3_pkg::NLANE]
);
  import mi3_pkg::*;

  pp_t  plo_r [3];
  pp_t  phi_r [3];
  adj_t a1_r [NLANE];
  adj_t a2_r [NLANE];
  det_t det_r;
  logic v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= adj_valid;
      v2_r <= v1_r;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_pp
    logic signed [SPLIT:0]  lo_s;
    logic signed [HI_W-1:0] hi_s;
    assign lo_s = {1'b0, adj[3*j][SPLIT-1:0]};
    assign hi_s = adj[3*j][ADJ_W-1:SPLIT];
    always_ff @(posedge clk) begin
      plo_r[j] <= PP_W'(mtop[j]) * PP_W'(lo_s);
      phi_r[j] <= PP_W'(mtop[j]) * PP_W'(hi_s);
    end
  end

  always_ff @(posedge clk) begin
    det_r <= DET_W'(plo_r[0]) + (DET_W'(phi_r[0]) <<< SPLIT)
           + DET_W'(plo_r[1]) + (DET_W'(phi_r[1]) <<< SPLIT)
           + DET_W'(plo_r[2]) + (DET_W'(phi_r[2]) <<< SPLIT);
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_dly
    always_ff @(posedge clk) begin
      a1_r[i] <= adj[i];
      a2_r[i] <= a1_r[i];
    end
    assign adj_out[i] = a2_r[i];
  end

  assign det_valid = v2_r;
  assign det       = det_r;

endmodule

// ----- design/mi3_prep.sv -----
// ----------------------------------------------------------------------------
// mi3_prep
// Magnitudes and signs, threshold test, rounded determinant and the
// dividend and divisor of the rounded quotient for each lane.
// ----------------------------------------------------------------------------
module mi3_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          det_valid,
  input  mi3_pkg::det_t                 det,
  input  mi3_pkg::adj_t                 adj [mi3_pkg::NLANE],
  input  logic [mi3_pkg::THR_W-1:0]     thr,
  output logic                          div_valid,
  output mi3_pkg::wide_t                div_num [mi3_pkg::NLANE],
  output mi3_pkg::wide_t                div_den,
  output logic [mi3_pkg::NLANE-1:0]     div_neg,
  output mi3_pkg::side_t                div_side
);
  import mi3_pkg::*;

  localparam wide_t LIM_POS = (wide_t'(1) << (ELEM_W - 1)) - wide_t'(1);
  localparam wide_t LIM_NEG = wide_t'(1) << (ELEM_W - 1);
  localparam wide_t HALF    = wide_t'(1) << (2 * FRAC_BITS - 1);

  logic                dneg_r;
  wide_t               dmag_r;
  logic [ADJ_W-1:0]    amag_r [NLANE];
  logic [NLANE-1:0]    aneg_r;
  logic                v1_r, v2_r;
  wide_t               num_r [NLANE];
  wide_t               den_r;
  logic [NLANE-1:0]    neg_r;
  side_t               side_r;

  wide_t dq;
  wide_t lim;
  wide_t dsat;
  wide_t dsgn;
  side_t side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= det_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dneg_r <= det[DET_W-1];
    dmag_r <= det[DET_W-1] ? wide_t'(-det) : wide_t'(det);
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    always_ff @(posedge clk) begin
      aneg_r[i] <= adj[i][ADJ_W-1];
      amag_r[i] <= adj[i][ADJ_W-1] ? ADJ_W'(-adj[i]) : ADJ_W'(adj[i]);
      // Rounding to nearest: (2N + D) / (2D) with N = |adj| scaled up.
      num_r[i] <= (wide_t'(amag_r[i]) << (2 * FRAC_BITS + 1)) + dmag_r;
      neg_r[i] <= aneg_r[i] ^ dneg_r;
    end
  end

  always_comb begin
    dq   = (dmag_r + HALF) >> (2 * FRAC_BITS);
    lim  = dneg_r ? LIM_NEG : LIM_POS;
    dsat = (dq > lim) ? lim : dq;
    dsgn = dneg_r ? -dsat : dsat;
    side_nxt.singular  = dmag_r <= (wide_t'(thr) << (2 * FRAC_BITS));
    side_nxt.det_clip  = dq > lim;
    side_nxt.det_value = dsgn[ELEM_W-1:0];
  end

  always_ff @(posedge clk) begin
    den_r  <= dmag_r << 1;
    side_r <= side_nxt;
  end

  assign div_valid = v2_r;
  assign div_num   = num_r;
  assign div_den   = den_r;
  assign div_neg   = neg_r;
  assign div_side  = side_r;

endmodule

// ----- design/mi3_div.sv -----
// ----------------------------------------------------------------------------
// mi3_div
// Nine restoring dividers, one quotient bit per stage, sharing the divisor.
// The first stage yields the overflow bit above the element range.
// ----------------------------------------------------------------------------
module mi3_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          div_valid,
  input  mi3_pkg::wide_t                div_num [mi3_pkg::NLANE],
  input  mi3_pkg::wide_t                div_den,
  input  logic [mi3_pkg::NLANE-1:0]     div_neg,
  input  mi3_pkg::side_t                div_side,
  output logic                          quo_valid,
  output mi3_pkg::quo_t                 quo [mi3_pkg::NLANE],
  output logic [mi3_pkg::NLANE-1:0]     quo_neg,
  output mi3_pkg::side_t                quo_side
);
  import mi3_pkg::*;

  wide_t            rem_r  [NSTG][NLANE];
  quo_t             q_r    [NSTG][NLANE];
  wide_t            den_r  [NSTG];
  logic [NLANE-1:0] neg_r  [NSTG];
  side_t            side_r [NSTG];
  logic [NSTG-1:0]  v_r;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int K = NSTG - 1 - s;
    wide_t            rem_p [NLANE];
    quo_t             q_p   [NLANE];
    wide_t            den_p;
    logic [NLANE-1:0] neg_p;
    side_t            side_p;
    logic             v_p;

    if (s == 0) begin : g_first
      assign rem_p  = div_num;
      assign den_p  = div_den;
      assign neg_p  = div_neg;
      assign side_p = div_side;
      assign v_p    = div_valid;
      for (genvar i = 0; i < NLANE; i++) begin : g_q0
        assign q_p[i] = '0;
      end
    end else begin : g_next
      assign rem_p  = rem_r[s-1];
      assign q_p    = q_r[s-1];
      assign den_p  = den_r[s-1];
      assign neg_p  = neg_r[s-1];
      assign side_p = side_r[s-1];
      assign v_p    = v_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      den_r[s]  <= den_p;
      neg_r[s]  <= neg_p;
      side_r[s] <= side_p;
    end

    for (genvar i = 0; i < NLANE; i++) begin : g_lane
      logic take;
      // Comparing the shifted remainder avoids widening the divisor.
      assign take = (rem_p[i] >> K) >= den_p;
      always_ff @(posedge clk) begin
        rem_r[s][i] <= take ? rem_p[i] - (den_p << K) : rem_p[i];
        q_r[s][i]   <= {q_p[i][QUO_W-2:0], take};
      end
    end
  end

  assign quo_valid = v_r[NSTG-1];
  assign quo       = q_r[NSTG-1];
  assign quo_neg   = neg_r[NSTG-1];
  assign quo_side  = side_r[NSTG-1];

endmodule

// ----- design/matrix3x3_inverse_core.sv -----
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Inverse of a signed Q16.16 3x3 matrix by the adjugate, with determinant.
// ----------------------------------------------------------------------------
// The core takes one matrix in every clock cycle (busy is never raised) and
// delivers each result in order, as a one-cycle out_valid strobe; the
// receiver cannot stall it. Each result passes through the 33-stage
// restoring divider, one quotient bit per stage, behind six stages of
// multiply, determinant and operand preparation. The singular threshold is
// written through the cfg port, which is always ready; write it only while
// no matrix is in flight.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mi3_pkg::in_data_t             in_data,
  output logic                          out_valid,
  output mi3_pkg::out_data_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mi3_pkg::THR_W-1:0]     cfg_data
);
  import mi3_pkg::*;

  localparam quo_t LIM_POS = (quo_t'(1) << (ELEM_W - 1)) - quo_t'(1);
  localparam quo_t LIM_NEG = quo_t'(1) << (ELEM_W - 1);

  logic [THR_W-1:0] thr_r;

  logic             adj_valid;
  adj_t             adj [NLANE];
  elem_t            mtop [3];
  logic             det_valid;
  det_t             det;
  adj_t             adj_d [NLANE];
  logic             div_valid;
  wide_t            div_num [NLANE];
  wide_t            div_den;
  logic [NLANE-1:0] div_neg;
  side_t            div_side;
  logic             quo_valid;
  quo_t             quo [NLANE];
  logic [NLANE-1:0] quo_neg;
  side_t            quo_side;

  elem_t            inv [NLANE];
  logic [NLANE-1:0] clip;
  logic             out_valid_r;
  out_data_t        out_data_r;
  out_data_t        out_data_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  mi3_adj u_adj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_data   (in_data),
    .adj_valid (adj_valid),
    .adj       (adj),
    .mtop      (mtop)
  );

  mi3_det u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .adj_valid (adj_valid),
    .adj       (adj),
    .mtop      (mtop),
    .det_valid (det_valid),
    .det       (det),
    .adj_out   (adj_d)
  );

  mi3_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .det_valid (det_valid),
    .det       (det),
    .adj       (adj_d),
    .thr       (thr_r),
    .div_valid (div_valid),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_neg   (div_neg),
    .div_side  (div_side)
  );

  mi3_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_valid (div_valid),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_neg   (div_neg),
    .div_side  (div_side),
    .quo_valid (quo_valid),
    .quo       (quo),
    .quo_neg   (quo_neg),
    .quo_side  (quo_side)
  );

  // A zero quotient is never given a negative sign.
  for (genvar i = 0; i < NLANE; i++) begin : g_sat
    logic neg;
    quo_t lim;
    quo_t mag;
    quo_t sgn;
    always_comb begin
      neg     = quo_neg[i] && (quo[i] != '0);
      lim     = neg ? LIM_NEG : LIM_POS;
      clip[i] = !quo_side.singular && (quo[i] > lim);
      mag     = (quo[i] > lim) ? lim : quo[i];
      sgn     = neg ? -mag : mag;
      inv[i]  = quo_side.singular ? '0 : sgn[ELEM_W-1:0];
    end
  end

  always_comb begin
    out_data_nxt.inv_r0c0  = inv[0];
    out_data_nxt.inv_r0c1  = inv[1];
    out_data_nxt.inv_r0c2  = inv[2];
    out_data_nxt.inv_r1c0  = inv[3];
    out_data_nxt.inv_r1c1  = inv[4];
    out_data_nxt.inv_r1c2  = inv[5];
    out_data_nxt.inv_r2c0  = inv[6];
    out_data_nxt.inv_r2c1  = inv[7];
    out_data_nxt.inv_r2c2  = inv[8];
    out_data_nxt.det_value = quo_side.det_value;
    out_data_nxt.singular  = quo_side.singular;
    out_data_nxt.saturated = quo_side.det_clip || (|clip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
